[rtl/core/rthsv_pkg.sv]
`timescale 1ns / 1ps

package rthsv_pkg;

    // Channel and result widths.
    localparam int CHAN_W = 8;
    localparam int HUE_W  = 9;

    // The long divider gives an 8-bit quotient, one bit per pipeline stage.
    localparam int DIV_STEPS = 8;
    localparam int QUO_W     = DIV_STEPS;
    localparam int REM_W     = 2 * CHAN_W;

    // Start of each hue sector in degrees.
    localparam logic [HUE_W-1:0] HUE_BASE_RED   = 9'd0;
    localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 9'd240;
    localparam logic [HUE_W-1:0] HUE_FULL_TURN  = 9'd360;

    // Which channel holds the maximum; ties go to red, then green.
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } max_sel_t;

    // First prep stage: maximum, minimum and the two hue operands.
    typedef struct packed {
        max_sel_t            sel;
        logic [CHAN_W-1:0]   mx;
        logic [CHAN_W-1:0]   mn;
        logic [CHAN_W-1:0]   opa;
        logic [CHAN_W-1:0]   opb;
    } prep_t;

    // Facts about the pixel that travel alongside the divider.
    typedef struct packed {
        max_sel_t            sel;
        logic                neg;
        logic                gray;
        logic                black;
        logic [CHAN_W-1:0]   mx;
    } side_t;

    // One division in flight: running remainder, divisor and quotient bits.
    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [CHAN_W-1:0]   dvs;
        logic [QUO_W-1:0]    quo;
    } div_lane_t;

    typedef struct packed {
        div_lane_t           hue;
        div_lane_t           sat;
        side_t               side;
    } div_item_t;

endpackage

[rtl/core/rthsv_if.sv]
`timescale 1ns / 1ps

interface rthsv_rgb_if;
    logic                          valid;
    logic                          ready;
    logic [rthsv_pkg::CHAN_W-1:0]  red;
    logic [rthsv_pkg::CHAN_W-1:0]  green;
    logic [rthsv_pkg::CHAN_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rthsv_hsv_if;
    logic                          valid;
    logic                          ready;
    logic [rthsv_pkg::HUE_W-1:0]   hue;
    logic [rthsv_pkg::CHAN_W-1:0]  saturation;
    logic [rthsv_pkg::CHAN_W-1:0]  brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

[rtl/core/rthsv_prep.sv]
`timescale 1ns / 1ps

module rthsv_prep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rthsv_pkg::CHAN_W-1:0]  red,
    input  logic [rthsv_pkg::CHAN_W-1:0]  green,
    input  logic [rthsv_pkg::CHAN_W-1:0]  blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rthsv_pkg::div_item_t          out_item
);

    logic                  a_valid_reg;
    rthsv_pkg::prep_t      a_reg;
    rthsv_pkg::prep_t      a_next;
    logic                  a_ready;

    logic                  b_valid_reg;
    rthsv_pkg::div_item_t  b_reg;
    rthsv_pkg::div_item_t  b_next;
    logic                  b_ready;

    logic [rthsv_pkg::CHAN_W:0]    diff;
    logic [rthsv_pkg::CHAN_W-1:0]  diff_abs;
    logic [rthsv_pkg::CHAN_W-1:0]  delta;

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    // Stage A: pick the largest channel and the operands of the hue difference.
    always_comb
    begin
        a_next = '0;
        if (red >= green && red >= blue)
        begin
            a_next.sel = rthsv_pkg::SEL_RED;
            a_next.mx  = red;
            a_next.opa = green;
            a_next.opb = blue;
        end
        else if (green >= blue)
        begin
            a_next.sel = rthsv_pkg::SEL_GREEN;
            a_next.mx  = green;
            a_next.opa = blue;
            a_next.opb = red;
        end
        else
        begin
            a_next.sel = rthsv_pkg::SEL_BLUE;
            a_next.mx  = blue;
            a_next.opa = red;
            a_next.opb = green;
        end
        a_next.mn = red;
        if (green < a_next.mn)
        begin
            a_next.mn = green;
        end
        if (blue < a_next.mn)
        begin
            a_next.mn = blue;
        end
    end

    // Stage B: delta, magnitude of the difference and both dividends.
    always_comb
    begin
        delta    = a_reg.mx - a_reg.mn;
        diff     = {1'b0, a_reg.opa} - {1'b0, a_reg.opb};
        diff_abs = diff[rthsv_pkg::CHAN_W] ? (a_reg.opb - a_reg.opa) : diff[rthsv_pkg::CHAN_W-1:0];

        b_next            = '0;
        // 60 * |diff| as 64x - 4x; 255 * delta as 256x - x.
        b_next.hue.rem    = ({2'd0, diff_abs, 6'd0} - {6'd0, diff_abs, 2'd0});
        b_next.hue.dvs    = delta;
        b_next.sat.rem    = {delta, 8'd0} - {8'd0, delta};
        b_next.sat.dvs    = a_reg.mx;
        b_next.side.sel   = a_reg.sel;
        b_next.side.neg   = diff[rthsv_pkg::CHAN_W];
        b_next.side.gray  = (delta == '0);
        b_next.side.black = (a_reg.mx == '0);
        b_next.side.mx    = a_reg.mx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_reg <= a_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_reg;

endmodule

[rtl/core/rthsv_divider.sv]
`timescale 1ns / 1ps

module rthsv_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rthsv_pkg::div_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rthsv_pkg::div_item_t  out_item
);

    logic                  valid_reg  [rthsv_pkg::DIV_STEPS];
    rthsv_pkg::div_item_t  item_reg   [rthsv_pkg::DIV_STEPS];
    rthsv_pkg::div_item_t  item_next  [rthsv_pkg::DIV_STEPS];
    rthsv_pkg::div_item_t  stage_in   [rthsv_pkg::DIV_STEPS];
    logic                  stage_in_valid [rthsv_pkg::DIV_STEPS];
    logic                  stage_ready    [rthsv_pkg::DIV_STEPS];
    logic                  down_ready     [rthsv_pkg::DIV_STEPS];

    // Restoring division, one quotient bit per stage, most significant first.
    // Both quotients are known to fit in eight bits, so eight steps suffice.
    for (genvar k = 0; k < rthsv_pkg::DIV_STEPS; k++)
    begin : g_step
        localparam int SH = rthsv_pkg::DIV_STEPS - 1 - k;

        logic [rthsv_pkg::REM_W-1:0] hue_trial;
        logic [rthsv_pkg::REM_W-1:0] sat_trial;

        if (k == 0)
        begin : g_first
            assign stage_in[k]       = in_item;
            assign stage_in_valid[k] = in_valid;
        end
        else
        begin : g_rest
            assign stage_in[k]       = item_reg[k-1];
            assign stage_in_valid[k] = valid_reg[k-1];
        end

        if (k == rthsv_pkg::DIV_STEPS - 1)
        begin : g_last
            assign down_ready[k] = out_ready;
        end
        else
        begin : g_mid
            assign down_ready[k] = stage_ready[k+1];
        end

        assign stage_ready[k] = !valid_reg[k] || down_ready[k];

        always_comb
        begin
            hue_trial    = {{rthsv_pkg::CHAN_W{1'b0}}, stage_in[k].hue.dvs} << SH;
            sat_trial    = {{rthsv_pkg::CHAN_W{1'b0}}, stage_in[k].sat.dvs} << SH;
            item_next[k] = stage_in[k];
            if (stage_in[k].hue.rem >= hue_trial)
            begin
                item_next[k].hue.rem     = stage_in[k].hue.rem - hue_trial;
                item_next[k].hue.quo[SH] = 1'b1;
            end
            if (stage_in[k].sat.rem >= sat_trial)
            begin
                item_next[k].sat.rem     = stage_in[k].sat.rem - sat_trial;
                item_next[k].sat.quo[SH] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (stage_ready[k])
            begin
                valid_reg[k] <= stage_in_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[k] && stage_in_valid[k])
            begin
                item_reg[k] <= item_next[k];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[rthsv_pkg::DIV_STEPS-1];
    assign out_item  = item_reg[rthsv_pkg::DIV_STEPS-1];

    a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted item did not reach the first divider stage");

    a_hue_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.side.gray |-> out_item.hue.rem < {8'd0, out_item.hue.dvs})
        else $error("hue remainder not below divisor");

    a_sat_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.side.black |-> out_item.sat.rem < {8'd0, out_item.sat.dvs})
        else $error("saturation remainder not below divisor");

endmodule

[rtl/core/rthsv_post.sv]
`timescale 1ns / 1ps

module rthsv_post (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rthsv_pkg::div_item_t          in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rthsv_pkg::HUE_W-1:0]   hue,
    output logic [rthsv_pkg::CHAN_W-1:0]  saturation,
    output logic [rthsv_pkg::CHAN_W-1:0]  brightness
);

    logic                          valid_reg;
    logic [rthsv_pkg::HUE_W-1:0]   hue_reg;
    logic [rthsv_pkg::HUE_W-1:0]   hue_next;
    logic [rthsv_pkg::CHAN_W-1:0]  sat_reg;
    logic [rthsv_pkg::CHAN_W-1:0]  sat_next;
    logic [rthsv_pkg::CHAN_W-1:0]  val_reg;
    logic [rthsv_pkg::HUE_W-1:0]   quo;
    logic [rthsv_pkg::HUE_W-1:0]   base;
    logic [rthsv_pkg::HUE_W-1:0]   rem_nz;

    assign in_ready = !valid_reg || out_ready;

    // The divider gives |offset| rounded down. A negative offset in the red
    // sector is truncated towards zero and wrapped; in the other sectors it
    // is floored, so a non-zero remainder takes one more degree off.
    always_comb
    begin
        quo    = {1'b0, in_item.hue.quo};
        rem_nz = {{(rthsv_pkg::HUE_W-1){1'b0}}, |in_item.hue.rem};
        unique case (in_item.side.sel)
            rthsv_pkg::SEL_RED:   base = rthsv_pkg::HUE_BASE_RED;
            rthsv_pkg::SEL_GREEN: base = rthsv_pkg::HUE_BASE_GREEN;
            rthsv_pkg::SEL_BLUE:  base = rthsv_pkg::HUE_BASE_BLUE;
            default:              base = rthsv_pkg::HUE_BASE_RED;
        endcase

        if (in_item.side.gray)
        begin
            hue_next = '0;
        end
        else if (!in_item.side.neg)
        begin
            hue_next = base + quo;
        end
        else if (in_item.side.sel == rthsv_pkg::SEL_RED)
        begin
            hue_next = (quo == '0) ? '0 : (rthsv_pkg::HUE_FULL_TURN - quo);
        end
        else
        begin
            hue_next = base - quo - rem_nz;
        end

        sat_next = in_item.side.black ? '0 : in_item.sat.quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= in_item.side.mx;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = val_reg;

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue < rthsv_pkg::HUE_FULL_TURN)
        else $error("hue outside a full turn");

endmodule

[rtl/core/rgb_to_hsv_pixel.sv]
// Pipeline: the result is registered behind two prep stages, eight divider
// stages and one output register.
// Throughput: one pixel per cycle while the receiver is ready; each stage
// holds one item and moves on whenever the stage after it is empty or
// moving, so bubbles close up.
// Reset: rst_n clears every valid bit asynchronously; payload is not reset.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel (
    input  logic          clk,
    input  logic          rst_n,
    rthsv_rgb_if.sink     rgb,
    rthsv_hsv_if.source   hsv
);

    // The pixel first has its largest and smallest channels found and the
    // sector chosen (red wins ties, then green). The second prep stage forms
    // delta, the magnitude of the hue difference, and the two dividends:
    // 60 times that magnitude over delta, and 255 times delta over max.
    // Both are constant multiplies made from shifts and one subtract.
    logic                  prep_valid;
    logic                  prep_ready;
    rthsv_pkg::div_item_t  prep_item;

    // Both divisions run side by side through an eight-stage restoring
    // divider, one quotient bit per stage. The quotients never exceed 255
    // because each dividend is below 256 times its divisor.
    logic                  div_valid;
    logic                  div_ready;
    rthsv_pkg::div_item_t  div_item;

    rthsv_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rgb.valid),
        .in_ready  (rgb.ready),
        .red       (rgb.red),
        .green     (rgb.green),
        .blue      (rgb.blue),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_item  (prep_item)
    );

    rthsv_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_item   (prep_item),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_item  (div_item)
    );

    // The final stage applies the sector offset and sign, wraps a negative
    // red-sector hue into range, forces hue to zero for a gray pixel and
    // saturation to zero for a black one, and holds the result until the
    // downstream transfer completes.
    rthsv_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .in_ready   (div_ready),
        .in_item    (div_item),
        .out_valid  (hsv.valid),
        .out_ready  (hsv.ready),
        .hue        (hsv.hue),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness)
    );

endmodule

[verif/rgb_to_hsv_pixel_tb.sv]
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_tb;

    localparam int CHAN_W = rthsv_pkg::CHAN_W;
    localparam int HUE_W  = rthsv_pkg::HUE_W;

    // Run control. The limit leaves a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 24;
    localparam int MAX_REPORTS  = 10;
    localparam int DEG_SECTOR   = 60;
    localparam int SAT_SCALE    = 255;

    // One converted pixel, at the widths of the result channel.
    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } hsv_pixel_t;

    // A row of the directed table. Where the answer is obvious it is typed
    // in; otherwise the row is checked against the predictor.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        bit                typed;
        hsv_pixel_t        want;
    } pixel_case_t;

    // Kinds of random pixel, chosen to reach the corners of the hue logic.
    typedef enum int {
        MIX_UNIFORM,
        MIX_GRAY,
        MIX_TIE,
        MIX_EXTREME,
        MIX_NEAR_GRAY,
        MIX_DARK
    } pixel_mix_t;

    localparam bit         TYPED     = 1'b1;
    localparam bit         PREDICTED = 1'b0;
    localparam hsv_pixel_t NO_WANT   = '0;
    localparam int         N_DIRECTED = 22;

    // The directed part: gray, black and white pixels, the three primaries,
    // every pair of tied maxima, a red-sector hue that wraps below zero, one
    // that truncates to zero, sectors where flooring differs from truncation,
    // single-step differences and alternating bit patterns.
    pixel_case_t directed_cases [N_DIRECTED] = '{
        '{8'd0,   8'd0,   8'd0,   TYPED,     '{9'd0,   8'd0,   8'd0}},
        '{8'd255, 8'd255, 8'd255, TYPED,     '{9'd0,   8'd0,   8'd255}},
        '{8'd128, 8'd128, 8'd128, TYPED,     '{9'd0,   8'd0,   8'd128}},
        '{8'd1,   8'd1,   8'd1,   TYPED,     '{9'd0,   8'd0,   8'd1}},
        '{8'd255, 8'd0,   8'd0,   TYPED,     '{9'd0,   8'd255, 8'd255}},
        '{8'd0,   8'd255, 8'd0,   TYPED,     '{9'd120, 8'd255, 8'd255}},
        '{8'd0,   8'd0,   8'd255, TYPED,     '{9'd240, 8'd255, 8'd255}},
        '{8'd0,   8'd0,   8'd1,   TYPED,     '{9'd240, 8'd255, 8'd1}},
        '{8'd255, 8'd255, 8'd0,   PREDICTED, NO_WANT},
        '{8'd0,   8'd255, 8'd255, PREDICTED, NO_WANT},
        '{8'd255, 8'd0,   8'd255, PREDICTED, NO_WANT},
        '{8'd255, 8'd0,   8'd1,   PREDICTED, NO_WANT},
        '{8'd255, 8'd0,   8'd10,  PREDICTED, NO_WANT},
        '{8'd10,  8'd200, 8'd3,   PREDICTED, NO_WANT},
        '{8'd3,   8'd10,  8'd200, PREDICTED, NO_WANT},
        '{8'd1,   8'd0,   8'd255, PREDICTED, NO_WANT},
        '{8'd0,   8'd1,   8'd0,   PREDICTED, NO_WANT},
        '{8'd255, 8'd254, 8'd254, PREDICTED, NO_WANT},
        '{8'd2,   8'd1,   8'd1,   PREDICTED, NO_WANT},
        '{8'd254, 8'd1,   8'd127, PREDICTED, NO_WANT},
        '{8'd170, 8'd85,  8'd255, PREDICTED, NO_WANT},
        '{8'd85,  8'd170, 8'd0,   PREDICTED, NO_WANT}
    };

    logic clk = 1'b0;
    logic rst_n;

    rthsv_rgb_if rgb_ch ();
    rthsv_hsv_if hsv_ch ();

    rgb_to_hsv_pixel dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rgb   (rgb_ch),
        .hsv   (hsv_ch)
    );

    // Expected conversions in order of input transfer, and the one that goes
    // with the pixel currently offered. The latter is updated with the
    // pixel itself, so the monitor sees the matching pair at the transfer.
    hsv_pixel_t hsv_expected [$];
    hsv_pixel_t offered_hsv;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_token;
    int cycle_count;
    int mismatch_count;
    int pixels_in;
    int results_checked;
    int input_stall_cycles;

    always #5 clk = ~clk;

    // Rounds a quotient towards minus infinity; the divisor is positive.
    function automatic int floor_quot(input int num, input int den);
        int q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    // Works out the hue, saturation and value of one pixel. Hue in the red
    // sector truncates towards zero and wraps by a full turn if negative;
    // the green and blue sectors floor before adding their base angle.
    function automatic hsv_pixel_t convert_pixel(input logic [CHAN_W-1:0] r,
                                                 input logic [CHAN_W-1:0] g,
                                                 input logic [CHAN_W-1:0] b);
        int                   ri, gi, bi;
        int                   peak, trough, span, deg, sat;
        rthsv_pkg::max_sel_t  which;
        hsv_pixel_t           res;
        ri = r;
        gi = g;
        bi = b;
        peak  = ri;
        which = rthsv_pkg::SEL_RED;
        if (gi > peak)
        begin
            peak  = gi;
            which = rthsv_pkg::SEL_GREEN;
        end
        if (bi > peak)
        begin
            peak  = bi;
            which = rthsv_pkg::SEL_BLUE;
        end
        trough = ri;
        if (gi < trough)
            trough = gi;
        if (bi < trough)
            trough = bi;
        span = peak - trough;
        deg  = 0;
        if (span != 0)
        begin
            case (which)
                rthsv_pkg::SEL_RED:
                begin
                    deg = (DEG_SECTOR * (gi - bi)) / span;
                    if (deg < 0)
                        deg = deg + int'(rthsv_pkg::HUE_FULL_TURN);
                end
                rthsv_pkg::SEL_GREEN:
                    deg = floor_quot(DEG_SECTOR * (bi - ri), span)
                          + int'(rthsv_pkg::HUE_BASE_GREEN);
                default:
                    deg = floor_quot(DEG_SECTOR * (ri - gi), span)
                          + int'(rthsv_pkg::HUE_BASE_BLUE);
            endcase
        end
        sat = (peak != 0) ? (SAT_SCALE * span) / peak : 0;
        res.hue        = HUE_W'(deg);
        res.saturation = CHAN_W'(sat);
        res.brightness = CHAN_W'(peak);
        return res;
    endfunction

    // Offers one pixel and returns at the edge of its transfer. The sender
    // may first idle for a random number of cycles, and valid stays high
    // afterwards so that back-to-back pixels need no second assignment.
    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b, input bit typed,
                              input hsv_pixel_t want);
        hsv_pixel_t exp_hsv;
        exp_hsv = typed ? want : convert_pixel(r, g, b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rgb_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rgb_ch.valid <= 1'b1;
        rgb_ch.red   <= r;
        rgb_ch.green <= g;
        rgb_ch.blue  <= b;
        offered_hsv  <= exp_hsv;
        do
            @(posedge clk);
        while (!rgb_ch.ready);
    endtask

    // Stops offering and waits until every expected result has arrived. The
    // extra edge lets the monitor record the final transfer first.
    task automatic drain_results();
        rgb_ch.valid <= 1'b0;
        @(posedge clk);
        while (hsv_expected.size() != 0)
            @(posedge clk);
    endtask

    // Sends a batch of random pixels. Half are uniform; the rest are grays,
    // tied maxima, all-or-nothing channels, near-grays and very dark pixels. At
    // the chosen index the receiver is asked for a long hold-off while the
    // pixels keep coming, which fills the pipeline and stalls the input.
    task automatic run_random(input int count, input int hold_at);
        logic [CHAN_W-1:0] r, g, b, v;
        pixel_mix_t        mix;
        for (int i = 0; i < count; i++)
        begin
            r = CHAN_W'($urandom_range(255));
            g = CHAN_W'($urandom_range(255));
            b = CHAN_W'($urandom_range(255));
            mix = ($urandom_range(99) < 50) ? MIX_UNIFORM
                                             : pixel_mix_t'($urandom_range(MIX_DARK, MIX_GRAY));
            case (mix)
                MIX_GRAY:
                begin
                    g = r;
                    b = r;
                end
                MIX_TIE:
                begin
                    v = CHAN_W'($urandom_range(255));
                    r = CHAN_W'($urandom_range(v));
                    g = CHAN_W'($urandom_range(v));
                    b = CHAN_W'($urandom_range(v));
                    case ($urandom_range(2))
                        0:
                        begin
                            r = v;
                            g = v;
                        end
                        1:
                        begin
                            g = v;
                            b = v;
                        end
                        default:
                        begin
                            r = v;
                            b = v;
                        end
                    endcase
                end
                MIX_EXTREME:
                begin
                    r = $urandom_range(1) ? 8'd255 : 8'd0;
                    g = $urandom_range(1) ? 8'd255 : 8'd0;
                    b = $urandom_range(1) ? 8'd255 : 8'd0;
                end
                MIX_NEAR_GRAY:
                begin
                    g = r ^ CHAN_W'($urandom_range(3));
                    b = r ^ CHAN_W'($urandom_range(3));
                end
                MIX_DARK:
                begin
                    r = CHAN_W'($urandom_range(3));
                    g = CHAN_W'($urandom_range(3));
                    b = CHAN_W'($urandom_range(3));
                end
                default:
                begin
                end
            endcase
            if (i == hold_at)
                hold_token <= hold_token + 1;
            send_pixel(r, g, b, PREDICTED, NO_WANT);
        end
    endtask

    // Receiver. Ready is drawn at random each cycle, except during a long
    // hold-off, which this process counts down itself once the stimulus
    // asks for one by bumping the token.
    always @(posedge clk)
    begin : receiver
        int hold_seen;
        int hold_left;
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hsv_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            hsv_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor. Every input transfer queues its expectation before any
    // output transfer of the same edge is checked against the oldest one.
    always @(posedge clk)
    begin : result_check
        hsv_pixel_t want;
        if (rst_n)
        begin
            if (rgb_ch.valid && rgb_ch.ready)
            begin
                hsv_expected.push_back(offered_hsv);
                pixels_in = pixels_in + 1;
            end
            if (rgb_ch.valid && !rgb_ch.ready)
                input_stall_cycles = input_stall_cycles + 1;
            if (hsv_ch.valid && hsv_ch.ready)
            begin
                if (hsv_expected.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: hue=%0d sat=%0d val=%0d",
                                 $realtime, hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness);
                end
                else
                begin
                    want = hsv_expected.pop_front();
                    results_checked = results_checked + 1;
                    if (hsv_ch.hue !== want.hue || hsv_ch.saturation !== want.saturation ||
                        hsv_ch.brightness !== want.brightness)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: mismatch: expected hue=%0d sat=%0d val=%0d, %s%0d %0d %0d",
                                     $realtime, want.hue, want.saturation, want.brightness,
                                     "got ", hsv_ch.hue, hsv_ch.saturation,
                                     hsv_ch.brightness);
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, hsv_expected.size());
            $display("** rgb_to_hsv_pixel: FAILED **");
            $finish;
        end
    end

    // Stimulus. Reset once, then the directed table, then three random
    // phases: a slow sender with a slower receiver (including the long
    // hold-off), the other way round, and finally both at full rate. The
    // sender pauses between phases until every result is back.
    initial
    begin
        rst_n              = 1'b0;
        rgb_ch.valid       = 1'b0;
        rgb_ch.red         = '0;
        rgb_ch.green       = '0;
        rgb_ch.blue        = '0;
        hsv_ch.ready       = 1'b0;
        offered_hsv        = '0;
        hold_token         = 0;
        cycle_count        = 0;
        mismatch_count     = 0;
        pixels_in          = 0;
        results_checked    = 0;
        input_stall_cycles = 0;
        send_idle_pct      = 28;
        recv_idle_pct      = 49;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cases[i])
            send_pixel(directed_cases[i].red, directed_cases[i].green,
                       directed_cases[i].blue, directed_cases[i].typed,
                       directed_cases[i].want);
        run_random(150, 40);
        drain_results();

        send_idle_pct = 49;
        recv_idle_pct <= 28;
        run_random(150, -1);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_random(130, -1);
        drain_results();

        // Anything arriving now would be an unexpected result.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d pixels (%0d from the directed table), %0d results checked.",
                 pixels_in, N_DIRECTED, results_checked);
        $display("Input was held off for %0d cycles; %0d mismatches.",
                 input_stall_cycles, mismatch_count);
        if (mismatch_count == 0)
            $display("** rgb_to_hsv_pixel: PASSED **");
        else
            $display("** rgb_to_hsv_pixel: FAILED **");
        $finish;
    end

endmodule

[rgb_to_hsv_pixel.f]
rtl/core/rthsv_pkg.sv
rtl/core/rthsv_if.sv
rtl/core/rthsv_prep.sv
rtl/core/rthsv_divider.sv
rtl/core/rthsv_post.sv
rtl/core/rgb_to_hsv_pixel.sv
verif/rgb_to_hsv_pixel_tb.sv
